[design/tbe_pkg.sv]
// shared types and constants for the termcap byte escaper
// no dependencies; imported by every module of the block
`default_nettype none

package tbe_pkg;

    // queue depth between classifier and emitter
    localparam int TBE_QUEUE_DEPTH = 2;

    // characters used in escaped forms
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CTRL_MAX     = 8'h1F;
    localparam logic [7:0] CODE_DEL     = 8'h7F;

    // bytes with a backslash letter escape
    localparam logic [7:0] CODE_ESC = 8'h1B;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_VT  = 8'h0B;

    // one classified byte: up to four characters and the index of the last
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
    } t_tbe_entry;

endpackage

`default_nettype wire

[design/tbe_front.sv]
// front end: accepts raw bytes, holds the mode register, builds escape entries
// depends on tbe_pkg
`default_nettype none

module tbe_front
    import tbe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_in_byte,
    output logic            o_in_stall,
    input  wire logic       i_octal_controls_we,
    input  wire logic       i_octal_controls,
    input  wire logic       i_queue_full,
    output logic            o_push,
    output t_tbe_entry      o_entry
);

    logic       r_octal;
    logic       n_octal;
    logic [7:0] letter;
    logic       letter_hit;

    // mode register
    always_comb begin
        n_octal = r_octal;
        if (i_octal_controls_we) begin
            n_octal = i_octal_controls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octal <= 1'b0;
        end else begin
            r_octal <= n_octal;
        end
    end

    // beat handshake: stall only while the queue is full
    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // named escapes
    always_comb begin
        letter_hit = 1'b1;
        unique case (i_in_byte)
            CODE_ESC:     letter = 8'h45;  // E
            CODE_CR:      letter = 8'h72;  // r
            CODE_LF:      letter = 8'h6E;  // n
            CODE_TAB:     letter = 8'h74;  // t
            CODE_BS:      letter = 8'h62;  // b
            CODE_VT:      letter = 8'h76;  // v
            CH_BACKSLASH: letter = CH_BACKSLASH;
            CH_CARET:     letter = CH_CARET;
            default: begin
                letter     = 8'h00;
                letter_hit = 1'b0;
            end
        endcase
    end

    // classify and build the character run
    always_comb begin
        o_entry.chars    = {4{CH_BACKSLASH}};
        o_entry.last_idx = 2'd0;
        priority if (letter_hit) begin
            o_entry.chars[1] = letter;
            o_entry.last_idx = 2'd1;
        end else if (!r_octal && i_in_byte <= CTRL_MAX) begin
            o_entry.chars[0] = CH_CARET;
            o_entry.chars[1] = CH_AT | i_in_byte;
            o_entry.last_idx = 2'd1;
        end else if (i_in_byte == CH_COLON || i_in_byte <= CTRL_MAX
                     || i_in_byte >= CODE_DEL) begin
            o_entry.chars[1] = CH_ZERO | {6'd0, i_in_byte[7:6]};
            o_entry.chars[2] = CH_ZERO | {5'd0, i_in_byte[5:3]};
            o_entry.chars[3] = CH_ZERO | {5'd0, i_in_byte[2:0]};
            o_entry.last_idx = 2'd3;
        end else begin
            o_entry.chars[0] = i_in_byte;
        end
    end

endmodule

`default_nettype wire

[design/tbe_queue.sv]
// short show-ahead queue of escape entries between front and back
// depends on tbe_pkg
`default_nettype none

module tbe_queue
    import tbe_pkg::*;
#(
    parameter int DEPTH = TBE_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_tbe_entry i_entry,
    input  wire logic       i_pop,
    output logic            o_full,
    output logic            o_empty,
    output t_tbe_entry      o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_tbe_entry       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // pointer and fill count update with wrap
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

[design/tbe_back.sv]
// back end: walks the head entry one character per beat into the output register
// depends on tbe_pkg
`default_nettype none

module tbe_back
    import tbe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_empty,
    input  wire t_tbe_entry i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_char,
    output logic            o_run_last
);

    logic       r_out_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic [1:0] r_idx;
    logic       n_out_valid;
    logic [1:0] n_idx;
    logic       out_free;
    logic       take;
    logic       at_last;

    // output register is free when empty or being taken
    assign out_free = !r_out_valid || !i_out_stall;
    assign take     = out_free && !i_empty;
    assign at_last  = (r_idx == i_head.last_idx);
    assign o_pop    = take && at_last;

    always_comb begin
        n_out_valid = r_out_valid;
        n_idx       = r_idx;
        if (out_free) begin
            n_out_valid = !i_empty;
        end
        if (take) begin
            n_idx = at_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else begin
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_char <= i_head.chars[r_idx];
            r_last <= at_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_char;
    assign o_run_last  = r_last;

endmodule

`default_nettype wire

[design/termcap_byte_escaper.sv]
// an accepted byte is written into the queue, then its first character into
// the output register; throughput: one character per cycle while the output
// is not stalled, set by the single-character output register
// a short queue lets input bytes be taken while the output is stalled
// reset: synchronous active low; clears queue, output valid and octal mode
`default_nettype none

module termcap_byte_escaper
    import tbe_pkg::*;
#(
    parameter int QUEUE_DEPTH = TBE_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_octal_controls_we,
    input  wire logic       i_octal_controls,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_char,
    output logic            o_run_last
);

    logic       push;
    logic       pop;
    logic       queue_full;
    logic       queue_empty;
    t_tbe_entry entry;
    t_tbe_entry head;

    // classify incoming bytes
    tbe_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_byte           (i_in_byte),
        .o_in_stall          (o_in_stall),
        .i_octal_controls_we (i_octal_controls_we),
        .i_octal_controls    (i_octal_controls),
        .i_queue_full        (queue_full),
        .o_push              (push),
        .o_entry             (entry)
    );

    // decoupling queue
    tbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_head  (head)
    );

    // emit characters
    tbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (queue_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_char  (o_out_char),
        .o_run_last  (o_run_last)
    );

endmodule

`default_nettype wire

[design/tbe_checker.sv]
// port-level checks for termcap_byte_escaper, attached by bind
// depends on tbe_pkg
`default_nettype none

module tbe_checker
    import tbe_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic [7:0] i_in_byte,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_char,
    input wire logic       o_run_last
);

    // after reset nothing is pending and input is open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // a stalled input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_byte))
        else $error("stalled input beat changed");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_char) && $stable(o_run_last))
        else $error("stalled output beat changed");

    // every non-final character is a backslash, caret or octal digit
    a_inner_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_last |->
            o_out_char == CH_BACKSLASH || o_out_char == CH_CARET
            || (o_out_char >= CH_ZERO && o_out_char <= CH_SEVEN))
        else $error("unexpected character inside an escape run");

    // an escape run opened by a caret always ends on the next character
    a_caret_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_run_last && o_out_char == CH_CARET
            |=> !o_out_valid || o_run_last)
        else $error("caret run longer than two characters");

endmodule

bind termcap_byte_escaper tbe_checker u_tbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_byte   (i_in_byte),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_char  (o_out_char),
    .o_run_last  (o_run_last)
);

`default_nettype wire

[dv/testbench.sv]
// self-checking testbench for termcap_byte_escaper: directed table, then random bytes
// depends on tbe_pkg and the termcap_byte_escaper rtl; predictor models escaping per byte
`timescale 1ns / 100ps

module testbench
    import tbe_pkg::*;
();

    // escaped form of one byte: up to four characters, first in chars[0]
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [2:0]      len;
    } t_escape;

    // one expected output beat
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_beat;

    // directed row: byte, mode, and typed escaped text ("" means use the predictor)
    typedef struct {
        logic [7:0] in_byte;
        logic       octal;
        string      want;
    } t_directed_row;

    localparam int N_DIRECTED     = 25;
    localparam int N_PHASES       = 8;
    localparam int ITEMS_PER_PHASE = 30;
    localparam int DRAIN_CYCLES   = 8;

    // bytes with a fixed two-character escape, plus colon and del
    localparam logic [7:0] NAMED_BYTES [10] = '{CODE_ESC, CODE_CR, CODE_LF, CODE_TAB,
        CODE_BS, CODE_VT, CH_BACKSLASH, CH_CARET, CH_COLON, CODE_DEL};

    t_directed_row directed_rows [N_DIRECTED] = '{
        '{8'h00, 1'b0, "^@"},
        '{8'h1F, 1'b0, "^_"},
        '{8'h0C, 1'b0, ""},
        '{CODE_ESC, 1'b0, "\\E"},
        '{CODE_CR, 1'b0, "\\r"},
        '{CODE_LF, 1'b0, "\\n"},
        '{CODE_TAB, 1'b0, "\\t"},
        '{CODE_BS, 1'b0, "\\b"},
        '{CODE_VT, 1'b0, "\\v"},
        '{CH_BACKSLASH, 1'b0, "\\\\"},
        '{CH_CARET, 1'b0, "\\^"},
        '{CH_COLON, 1'b0, "\\072"},
        '{CODE_DEL, 1'b0, "\\177"},
        '{8'h80, 1'b0, "\\200"},
        '{8'hFF, 1'b0, "\\377"},
        '{8'h41, 1'b0, ""},
        '{8'h20, 1'b0, ""},
        '{8'h7E, 1'b0, ""},
        '{8'h00, 1'b1, "\\000"},
        '{8'h1F, 1'b1, "\\037"},
        '{8'h0C, 1'b1, ""},
        '{CODE_ESC, 1'b1, "\\E"},
        '{CODE_VT, 1'b1, "\\v"},
        '{CODE_DEL, 1'b1, ""},
        '{CH_COLON, 1'b1, ""}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_octal_controls_we = 1'b0;
    logic       i_octal_controls = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_out_char;
    logic       o_run_last;

    t_char_beat pending_chars [$];
    logic       octal_mode = 1'b0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         err_count = 0;

    termcap_byte_escaper dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_in_byte           (i_in_byte),
        .i_octal_controls_we (i_octal_controls_we),
        .i_octal_controls    (i_octal_controls),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_char          (o_out_char),
        .o_run_last          (o_run_last)
    );

    always #10 i_clk = ~i_clk;

    // escaped text of one byte under the given control mode
    function automatic t_escape escape_byte(input logic [7:0] b, input logic octal);
        t_escape    e;
        logic [7:0] letter;
        e.chars = '0;
        e.len = 3'd0;
        letter = 8'h00;
        case (b)
            CODE_ESC:     letter = "E";
            CODE_CR:      letter = "r";
            CODE_LF:      letter = "n";
            CODE_TAB:     letter = "t";
            CODE_BS:      letter = "b";
            CODE_VT:      letter = "v";
            CH_BACKSLASH: letter = CH_BACKSLASH;
            CH_CARET:     letter = CH_CARET;
            default:      letter = 8'h00;
        endcase
        if (letter != 8'h00) begin
            e.chars[0] = CH_BACKSLASH;
            e.chars[1] = letter;
            e.len = 3'd2;
        end else if (!octal && b <= CTRL_MAX) begin
            e.chars[0] = CH_CARET;
            e.chars[1] = CH_AT + b;
            e.len = 3'd2;
        end else if (b == CH_COLON || b <= CTRL_MAX || b >= CODE_DEL) begin
            e.chars[0] = CH_BACKSLASH;
            e.chars[1] = CH_ZERO + {6'd0, b[7:6]};
            e.chars[2] = CH_ZERO + {5'd0, b[5:3]};
            e.chars[3] = CH_ZERO + {5'd0, b[2:0]};
            e.len = 3'd4;
        end else begin
            e.chars[0] = b;
            e.len = 3'd1;
        end
        return e;
    endfunction

    // offer one byte, wait for its beat, queue its characters, then maybe go idle
    task automatic send_byte(input logic [7:0] b, input t_escape e);
        i_in_byte <= b;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        for (int k = 0; k < e.len; k++)
            pending_chars.push_back('{e.chars[k], (k == e.len - 1)});
        if ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_byte <= 8'($urandom_range(0, 255));
            @(posedge i_clk);
            while ($urandom_range(0, 99) < idle_pct) @(posedge i_clk);
        end
    endtask

    // write the mode register once the block has drained
    task automatic set_mode(input logic v);
        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_octal_controls_we <= 1'b1;
        i_octal_controls <= v;
        @(posedge i_clk);
        i_octal_controls_we <= 1'b0;
        octal_mode = v;
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // compare each output beat with the oldest expected character
    always @(posedge i_clk) begin : check_beat
        t_char_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_chars.size() == 0) begin
                err_count++;
                $display("%0t: unexpected beat char=%h last=%b", $time, o_out_char,
                         o_run_last);
            end else begin
                want = pending_chars.pop_front();
                if (o_out_char !== want.ch) begin
                    err_count++;
                    $display("%0t: out_char expected %h actual %h", $time, want.ch,
                             o_out_char);
                end
                if (o_run_last !== want.last) begin
                    err_count++;
                    $display("%0t: run_last expected %b actual %b", $time, want.last,
                             o_run_last);
                end
            end
        end
    end

    // main sequence: reset, directed table, random phases, drain
    initial begin
        t_escape    e;
        logic [7:0] b;
        int         idle_set [4];
        int         stall_set [4];
        idle_set = '{0, 50, 0, 14};
        stall_set = '{0, 0, 50, 14};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows, typed text where given
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].octal != octal_mode)
                set_mode(directed_rows[r].octal);
            if (directed_rows[r].want.len() == 0) begin
                e = escape_byte(directed_rows[r].in_byte, octal_mode);
            end else begin
                e.chars = '0;
                e.len = 3'(directed_rows[r].want.len());
                for (int k = 0; k < e.len; k++)
                    e.chars[k] = directed_rows[r].want[k];
            end
            send_byte(directed_rows[r].in_byte, e);
        end

        // random phases over both modes and every idling setting
        for (int p = 0; p < N_PHASES; p++) begin
            set_mode(p[0] ^ p[2]);
            idle_pct = idle_set[p % 4];
            stall_pct = stall_set[p % 4];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(0, 9))
                    5, 6:    b = 8'($urandom_range(0, 31));
                    7:       b = NAMED_BYTES[$urandom_range(0, 9)];
                    8:       b = 8'($urandom_range(127, 255));
                    9:       b = 8'($urandom_range(32, 126));
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_byte(b, escape_byte(b, octal_mode));
            end
        end

        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
design/tbe_pkg.sv
design/tbe_front.sv
design/tbe_queue.sv
design/tbe_back.sv
design/termcap_byte_escaper.sv
design/tbe_checker.sv
dv/testbench.sv
